### hw/rtl/rmbb_pkg.sv
// ----------------------------------------------------------------------------
// rmbb_pkg
// Shared codes, field widths and reset values of the raster-to-block buffer.
// ----------------------------------------------------------------------------
package rmbb_pkg;

	// field widths
	localparam int DATA_BITS      = 8;
	localparam int OP_BITS        = 2;
	localparam int STATUS_BITS    = 2;
	localparam int FMT_BITS       = 3;
	localparam int CFG_WIDTH_BITS = 12;
	localparam int ORDER_BITS     = 24;
	localparam int SLOT_BITS      = 4;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 24;

	// operations
	localparam logic [OP_BITS-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_BITS-1:0] OP_READ  = 2'd1;
	localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

	// result status
	localparam logic [STATUS_BITS-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_DROP      = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_NOT_READY = 2'd2;

	// sampling formats
	localparam logic [FMT_BITS-1:0] FMT_GRAY = 3'd0;
	localparam logic [FMT_BITS-1:0] FMT_411  = 3'd1;
	localparam logic [FMT_BITS-1:0] FMT_420  = 3'd2;
	localparam logic [FMT_BITS-1:0] FMT_422  = 3'd3;
	localparam logic [FMT_BITS-1:0] FMT_444  = 3'd4;

	// stream slot codes
	localparam logic [SLOT_BITS-1:0] SLOT_Y0   = 4'd0;
	localparam logic [SLOT_BITS-1:0] SLOT_U    = 4'd1;
	localparam logic [SLOT_BITS-1:0] SLOT_V    = 4'd2;
	localparam logic [SLOT_BITS-1:0] SLOT_Y1   = 4'd3;
	localparam logic [SLOT_BITS-1:0] SLOT_Y2   = 4'd4;
	localparam logic [SLOT_BITS-1:0] SLOT_Y3   = 4'd5;
	localparam logic [SLOT_BITS-1:0] SLOT_NONE = 4'd15;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_FORMAT = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ORDER  = 2'd2;

	// register reset values
	localparam logic [FMT_BITS-1:0]       FMT_RESET   = FMT_422;
	localparam logic [CFG_WIDTH_BITS-1:0] WIDTH_RESET = 12'd640;
	localparam logic [ORDER_BITS-1:0]     ORDER_RESET = 24'h543210;

	// block layout offsets inside an MCU
	localparam int BLK_WORDS   = 64;
	localparam int CHROMA_OFS  = 256;

	typedef struct packed {
		logic [DATA_BITS-1:0]   data;
		logic [STATUS_BITS-1:0] status;
	} res_t;

endpackage

### hw/rtl/rmbb_ram.sv
// ----------------------------------------------------------------------------
// rmbb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rmbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 49152
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/raster_to_mcu_block_buffer_unit.sv
// ----------------------------------------------------------------------------
// raster_to_mcu_block_buffer_unit
// Raster-to-8x8-block reorder buffer for a JPEG encoder front end.
// ----------------------------------------------------------------------------
// Raster samples of one strip (8 lines, 16 for 4:2:0) come in one per
// transaction and are written straight into a strip RAM at their JPEG block
// address (Y blocks, then U, then V per MCU). Read transactions return the
// stored words in linear block order; the read pointer wraps at the padded
// strip size. Every input transaction gives exactly one result transaction.
// Rate: one transaction per cycle while the output queue has room; a result is
// registered in stage 1 (the strip RAM's read register), then in the queue. A
// three-entry output queue lets input continue while results wait for
// out_ready. After reset the strip RAM is swept to zero, one word per cycle,
// over all 24*MAX_WIDTH words (49152 by default); in_ready stays low until the
// sweep is done, while the configuration port stays open. Any configuration
// write to a known index clears the write counters and the read pointer.
// ----------------------------------------------------------------------------
module raster_to_mcu_block_buffer_unit
	import rmbb_pkg::*;
#(
	parameter int MAX_WIDTH   = 2048,
	parameter int SAMPLE_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	// input channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [OP_BITS-1:0]        op,
	input  logic [DATA_BITS-1:0]      sample,
	// result channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [DATA_BITS-1:0]      read_data,
	output logic [STATUS_BITS-1:0]    status
);

	// geometry widths
	localparam int DEPTH     = 24 * MAX_WIDTH;           // strip RAM words
	localparam int A_BITS    = $clog2(DEPTH);            // RAM address
	localparam int CNT_BITS  = $clog2(DEPTH + 1);        // counts up to DEPTH
	localparam int W_BITS    = $clog2(MAX_WIDTH + 1);    // effective width
	localparam int PAD_BITS  = $clog2(24 * (MAX_WIDTH + 32) + 1);
	localparam int CMP_BITS  = (W_BITS > CFG_WIDTH_BITS) ? W_BITS : CFG_WIDTH_BITS;
	localparam int FIFO_DEPTH = 3;
	localparam int FP_BITS   = $clog2(FIFO_DEPTH);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [FMT_BITS-1:0]       format_q;
	logic [CFG_WIDTH_BITS-1:0] width_q;
	logic [ORDER_BITS-1:0]     order_q;
	logic                      cfg_fire;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_RESET;
			width_q  <= WIDTH_RESET;
			order_q  <= ORDER_RESET;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				REG_FORMAT: format_q <= cfg_data[FMT_BITS-1:0];
				REG_WIDTH:  width_q  <= cfg_data[CFG_WIDTH_BITS-1:0];
				REG_ORDER:  order_q  <= cfg_data[ORDER_BITS-1:0];
				default: ;  // unknown index: ignored
			endcase
		end
	end

	// a write to an unknown index leaves the pointers alone
	logic cfg_clear;
	assign cfg_clear = cfg_fire && (cfg_index == REG_FORMAT || cfg_index == REG_WIDTH ||
		cfg_index == REG_ORDER);

	// ------------------------------------------------------------------
	// Write/read pointers (kept in flops, updated at the accept edge or cleared by a config write)
	// ------------------------------------------------------------------
	logic [CNT_BITS-1:0] write_count_q;
	logic [W_BITS-1:0]   pack_column_q;
	logic [3:0]          line_row_q;
	logic [2:0]          pack_pos_q;
	logic [A_BITS-1:0]   read_ptr_q;

	// RAM clear sweep after reset
	logic              clr_busy_q;
	logic [A_BITS-1:0] clr_addr_q;

	// ------------------------------------------------------------------
	// Geometry decode from the configuration
	// ------------------------------------------------------------------
	logic [FMT_BITS-1:0] fmt;
	logic [W_BITS-1:0]   w_cap;
	logic [W_BITS-1:0]   w;
	logic [CNT_BITS-1:0] w_c;
	logic [CNT_BITS-1:0] strip;
	logic [CNT_BITS-1:0] line_thr;
	logic [PAD_BITS-1:0] w_p;
	logic [PAD_BITS-1:0] pad_raw;
	logic [CNT_BITS-1:0] mem_size;
	logic [W_BITS-1:0]   ppl;
	logic [2:0]          plen;

	always_comb begin
		fmt = (format_q > FMT_444) ? FMT_444 : format_q;

		w_cap = (CMP_BITS'(width_q) > CMP_BITS'(MAX_WIDTH)) ? W_BITS'(MAX_WIDTH)
			: W_BITS'(width_q);
		if (fmt == FMT_411) begin
			w = w_cap & ~W_BITS'(3);
		end else if (fmt == FMT_420 || fmt == FMT_422) begin
			w = w_cap & ~W_BITS'(1);
		end else begin
			w = w_cap;
		end

		w_c = CNT_BITS'(w);
		w_p = PAD_BITS'(w);
		unique case (fmt)
			FMT_GRAY: begin
				strip   = w_c << 3;
				w_p     = (w_p + PAD_BITS'(7)) & ~PAD_BITS'(7);
				pad_raw = w_p << 3;
				ppl     = w;
				plen    = 3'd1;
			end
			FMT_411: begin
				strip   = (w_c << 3) + (w_c << 2);
				w_p     = (w_p + PAD_BITS'(31)) & ~PAD_BITS'(31);
				pad_raw = (w_p << 3) + (w_p << 2);
				ppl     = w >> 2;
				plen    = 3'd6;
			end
			FMT_420: begin
				strip   = (w_c << 4) + (w_c << 3);
				w_p     = (w_p + PAD_BITS'(15)) & ~PAD_BITS'(15);
				pad_raw = (w_p << 4) + (w_p << 3);
				ppl     = w >> 1;
				plen    = line_row_q[0] ? 3'd2 : 3'd4;  // odd rows: luma pairs only
			end
			FMT_422: begin
				strip   = w_c << 4;
				w_p     = (w_p + PAD_BITS'(15)) & ~PAD_BITS'(15);
				pad_raw = w_p << 4;
				ppl     = w >> 1;
				plen    = 3'd4;
			end
			default: begin  // 4:4:4
				strip   = (w_c << 4) + (w_c << 3);
				w_p     = (w_p + PAD_BITS'(7)) & ~PAD_BITS'(7);
				pad_raw = (w_p << 4) + (w_p << 3);
				ppl     = w;
				plen    = 3'd3;
			end
		endcase

		mem_size = (pad_raw > PAD_BITS'(DEPTH)) ? CNT_BITS'(DEPTH) : CNT_BITS'(pad_raw);
		// one raster line (a row pair for 4:2:0) must be in before reading
		line_thr = strip >> 3;
	end

	// ------------------------------------------------------------------
	// Block address of the incoming sample
	// ------------------------------------------------------------------
	logic [SLOT_BITS-1:0] slot;
	logic [PAD_BITS-1:0]  kb;
	logic [PAD_BITS-1:0]  mcu192;
	logic [PAD_BITS-1:0]  mcu256;
	logic [PAD_BITS-1:0]  mcu384;
	logic [PAD_BITS-1:0]  y_addr;
	logic [PAD_BITS-1:0]  c_addr;
	logic [PAD_BITS-1:0]  addr;
	logic                 addr_ok;
	logic [W_BITS-1:0]    k;
	logic [3:0]           r;
	logic [2:0]           p;

	always_comb begin
		k = pack_column_q;
		r = line_row_q;
		p = pack_pos_q;

		unique case (p)
			3'd0: slot = order_q[3:0];
			3'd1: slot = order_q[7:4];
			3'd2: slot = order_q[11:8];
			3'd3: slot = order_q[15:12];
			3'd4: slot = order_q[19:16];
			3'd5: slot = order_q[23:20];
			default: slot = SLOT_NONE;
		endcase

		// MCU base: (k / 8) times the MCU size, built from shifts
		kb     = PAD_BITS'(k >> 3);
		mcu192 = (kb << 7) + (kb << 6);
		mcu256 = kb << 8;
		mcu384 = (kb << 8) + (kb << 7);

		y_addr  = '0;
		c_addr  = '0;
		addr    = '0;
		addr_ok = 1'b0;

		unique case (fmt)
			FMT_GRAY: begin
				addr    = (kb << 6) + PAD_BITS'({r[2:0], k[2:0]});
				addr_ok = 1'b1;
			end
			FMT_422: begin
				y_addr = mcu256 + PAD_BITS'({k[2], r[2:0], k[1:0], 1'b0});
				c_addr = mcu256 + PAD_BITS'({2'b10, r[2:0], k[2:0]});
			end
			FMT_420: begin
				y_addr = mcu384 + PAD_BITS'({r[3], k[2], r[2:0], k[1:0], 1'b0});
				c_addr = mcu384 + PAD_BITS'(CHROMA_OFS) + PAD_BITS'({r[3:0], 2'b00})
					+ PAD_BITS'(k[2:0]);
			end
			FMT_411: begin
				y_addr = mcu384 + PAD_BITS'({k[2:1], r[2:0], k[0], 2'b00});
				c_addr = mcu384 + PAD_BITS'(CHROMA_OFS) + PAD_BITS'({r[2:0], k[2:0]});
			end
			default: begin  // 4:4:4, Y U V in fixed order
				addr    = mcu192 + PAD_BITS'({p[1:0], r[2:0], k[2:0]});
				addr_ok = 1'b1;
			end
		endcase

		if (fmt == FMT_420 && r[0]) begin
			// odd 4:2:0 row: luma pair in fixed order
			addr    = y_addr + PAD_BITS'(p[0]);
			addr_ok = 1'b1;
		end else if (fmt == FMT_411 && slot == SLOT_Y2) begin
			addr    = y_addr + PAD_BITS'(2);
			addr_ok = 1'b1;
		end else if (fmt == FMT_411 && slot == SLOT_Y3) begin
			addr    = y_addr + PAD_BITS'(3);
			addr_ok = 1'b1;
		end else if (fmt == FMT_411 || fmt == FMT_420 || fmt == FMT_422) begin
			priority if (slot == SLOT_Y0) begin
				addr    = y_addr;
				addr_ok = 1'b1;
			end else if (slot == SLOT_Y1) begin
				addr    = y_addr + PAD_BITS'(1);
				addr_ok = 1'b1;
			end else if (slot == SLOT_U) begin
				addr    = c_addr;
				addr_ok = 1'b1;
			end else if (slot == SLOT_V) begin
				addr    = c_addr + PAD_BITS'(BLK_WORDS);
				addr_ok = 1'b1;
			end else begin
				addr_ok = 1'b0;  // slot has no place in this format
			end
		end
	end

	// ------------------------------------------------------------------
	// Operation decode for the accepted transaction
	// ------------------------------------------------------------------
	logic                   in_fire;
	logic [STATUS_BITS-1:0] op_status;
	logic                   do_store;
	logic                   do_read;
	logic                   do_adv;
	logic                   do_clear;

	assign in_fire = in_valid && in_ready;

	always_comb begin
		op_status = ST_DONE;
		do_store  = 1'b0;
		do_read   = 1'b0;
		do_adv    = 1'b0;
		do_clear  = 1'b0;
		unique case (op)
			OP_WRITE: begin
				if (w == '0 || write_count_q >= strip) begin
					op_status = ST_DROP;
				end else begin
					do_adv   = 1'b1;
					do_store = addr_ok && (addr < PAD_BITS'(DEPTH));
				end
			end
			OP_READ: begin
				if (w == '0 || mem_size == '0 || write_count_q < line_thr) begin
					op_status = ST_NOT_READY;
				end else begin
					do_read = 1'b1;
				end
			end
			OP_CLEAR: do_clear = 1'b1;
			default: ;  // unused op: plain done
		endcase
	end

	// ------------------------------------------------------------------
	// Pointer update
	// ------------------------------------------------------------------
	logic [3:0]          pos_inc;
	logic [W_BITS-1:0]   col_inc;
	logic [CNT_BITS-1:0] rp_inc;

	assign pos_inc = {1'b0, pack_pos_q} + 4'd1;
	assign col_inc = pack_column_q + W_BITS'(1);
	assign rp_inc  = CNT_BITS'(read_ptr_q) + CNT_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_count_q <= '0;
			pack_column_q <= '0;
			line_row_q    <= '0;
			pack_pos_q    <= '0;
			read_ptr_q    <= '0;
		end else if (cfg_clear || (in_fire && do_clear)) begin
			write_count_q <= '0;
			pack_column_q <= '0;
			line_row_q    <= '0;
			pack_pos_q    <= '0;
			read_ptr_q    <= '0;
		end else if (in_fire) begin
			if (do_adv) begin
				write_count_q <= write_count_q + CNT_BITS'(1);
				if (pos_inc >= {1'b0, plen}) begin
					pack_pos_q <= '0;
					if (col_inc >= ppl) begin
						pack_column_q <= '0;
						line_row_q    <= line_row_q + 4'd1;
					end else begin
						pack_column_q <= col_inc;
					end
				end else begin
					pack_pos_q <= pos_inc[2:0];
				end
			end
			if (do_read) begin
				read_ptr_q <= (rp_inc == mem_size) ? '0 : rp_inc[A_BITS-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Strip RAM and its clear sweep
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == A_BITS'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + A_BITS'(1);
		end
	end

	logic                   ram_we;
	logic [A_BITS-1:0]      ram_waddr;
	logic [SAMPLE_BITS-1:0] ram_wdata;
	logic [SAMPLE_BITS-1:0] ram_rdata;

	assign ram_we    = clr_busy_q || (in_fire && do_store);
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr[A_BITS-1:0];
	assign ram_wdata = clr_busy_q ? '0 : SAMPLE_BITS'(sample);

	rmbb_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_strip_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_fire && do_read),
		.raddr (read_ptr_q),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Stage 1: RAM read data arrives; result is formed
	// ------------------------------------------------------------------
	logic                   res_valid_s1;
	logic                   res_read_s1;
	logic [STATUS_BITS-1:0] res_status_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else begin
			res_valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_read_s1   <= do_read;
			res_status_s1 <= op_status;
		end
	end

	res_t res_new;
	assign res_new.data   = res_read_s1 ? ram_rdata[DATA_BITS-1:0] : '0;
	assign res_new.status = res_status_s1;

	// ------------------------------------------------------------------
	// Output queue: room is reserved for the result still in stage 1
	// ------------------------------------------------------------------
	res_t               fifo_q [FIFO_DEPTH];
	logic [FP_BITS-1:0] wr_ptr_q;
	logic [FP_BITS-1:0] rd_ptr_q;
	logic [FP_BITS-1:0] count_q;
	logic               pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign read_data = fifo_q[rd_ptr_q].data;
	assign status    = fifo_q[rd_ptr_q].status;
	assign in_ready  = !clr_busy_q
		&& ((3'(count_q) + 3'(res_valid_s1)) < 3'(FIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (res_valid_s1) begin
			fifo_q[wr_ptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (res_valid_s1) begin
				wr_ptr_q <= (wr_ptr_q == FP_BITS'(FIFO_DEPTH - 1)) ? '0
					: wr_ptr_q + FP_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FP_BITS'(FIFO_DEPTH - 1)) ? '0
					: rd_ptr_q + FP_BITS'(1);
			end
			if (res_valid_s1 && !pop) begin
				count_q <= count_q + FP_BITS'(1);
			end else if (pop && !res_valid_s1) begin
				count_q <= count_q - FP_BITS'(1);
			end
		end
	end

endmodule

### bench/raster_to_mcu_block_buffer_unit_tb.sv
// ----------------------------------------------------------------------------
// raster_to_mcu_block_buffer_unit testbench
// Drives write, read, clear and spare transactions into the block buffer under
// many format, width and stream order settings, predicts every result with a
// behavioral model of the strip store, and checks each result in order.
// ----------------------------------------------------------------------------
module testbench;
	import rmbb_pkg::*;

	// opcode and register index with no name in the package
	localparam logic [OP_BITS-1:0]        OP_SPARE  = 2'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

	// store geometry, matches the default MAX_WIDTH of the unit
	localparam int unsigned MAX_W       = 2048;
	localparam int unsigned STORE_WORDS = 24 * MAX_W;
	localparam int unsigned NO_ADDR     = 32'hFFFF_FFFF;

	// the limit covers the post-reset sweep of STORE_WORDS words with a wide margin
	// over the slowest run (gaps and long receiver stalls)
	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic [OP_BITS-1:0]        op;
	logic [DATA_BITS-1:0]      sample;
	logic                      out_valid;
	logic                      out_ready;
	logic [DATA_BITS-1:0]      read_data;
	logic [STATUS_BITS-1:0]    status;

	// shadow registers and pointers of the buffer
	logic [FMT_BITS-1:0]       cfg_format;
	logic [CFG_WIDTH_BITS-1:0] cfg_width;
	logic [ORDER_BITS-1:0]     cfg_order;
	logic [DATA_BITS-1:0]      strip_image [STORE_WORDS];
	int unsigned               fill_count;
	int unsigned               pack_col;
	int unsigned               row_in_strip;
	int unsigned               pack_slot;
	int unsigned               read_ptr;

	// results predicted but not yet seen on the output channel
	res_t buffer_results_q[$];

	// run bookkeeping
	int unsigned cycle_count;
	int unsigned fail_count;
	int unsigned checked_count;
	int unsigned item_count;
	int unsigned setting_count;

	// idle control: sender bursts and receiver stall rate
	bit          idle_on;
	int          burst_left;
	int unsigned stall_pct;
	int          stall_left;

	raster_to_mcu_block_buffer_unit #(
		.MAX_WIDTH  (2048),
		.SAMPLE_BITS(8)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.sample   (sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.status   (status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycle_count, buffer_results_q.size());
			$display("[raster_to_mcu_block_buffer_unit] ERROR");
			$finish;
		end
	end

	// Receiver: ready most of the time, with stall runs whose frequency each test
	// sets through stall_pct (0 means never stall).
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 99) < stall_pct)
				stall_left = $urandom_range(1, 7);
		end
	end

	// ------------------------------------------------------------------
	// Buffer geometry. Formats above 4:4:4 fold onto it; the width is capped
	// at the store width and rounded down to the pack width.
	// ------------------------------------------------------------------
	function automatic logic [FMT_BITS-1:0] eff_format();
		return (cfg_format > FMT_444) ? FMT_444 : cfg_format;
	endfunction

	function automatic int unsigned eff_width();
		logic [FMT_BITS-1:0] f;
		int unsigned         w;
		f = eff_format();
		w = (cfg_width > MAX_W) ? MAX_W : cfg_width;
		if (f == FMT_411)
			w = w & ~32'd3;
		else if (f == FMT_420 || f == FMT_422)
			w = w & ~32'd1;
		return w;
	endfunction

	function automatic int unsigned strip_words(input logic [FMT_BITS-1:0] f,
		input int unsigned w);
		case (f)
			FMT_GRAY: return 8 * w;
			FMT_411:  return 12 * w;
			FMT_422:  return 16 * w;
			default:  return 24 * w;
		endcase
	endfunction

	// read wrap point: width rounded up to a whole MCU
	function automatic int unsigned padded_words();
		logic [FMT_BITS-1:0] f;
		int unsigned         w, s;
		f = eff_format();
		w = eff_width();
		case (f)
			FMT_411:          w = (w + 31) & ~32'd31;
			FMT_420, FMT_422: w = (w + 15) & ~32'd15;
			default:          w = (w + 7) & ~32'd7;
		endcase
		s = strip_words(f, w);
		return (s > STORE_WORDS) ? STORE_WORDS : s;
	endfunction

	// samples per pack; 4:2:0 odd rows carry only a luma pair
	function automatic int unsigned pack_words(input logic [FMT_BITS-1:0] f);
		case (f)
			FMT_GRAY: return 1;
			FMT_411:  return 6;
			FMT_420:  return row_in_strip[0] ? 2 : 4;
			FMT_422:  return 4;
			default:  return 3;
		endcase
	endfunction

	function automatic int unsigned packs_in_line(input logic [FMT_BITS-1:0] f,
		input int unsigned w);
		if (f == FMT_411)
			return w >> 2;
		if (f == FMT_420 || f == FMT_422)
			return w >> 1;
		return w;
	endfunction

	// Store address of the next sample. Y blocks of an MCU come first, then
	// U at the chroma offset, then V one block later.
	function automatic int unsigned block_addr(input logic [FMT_BITS-1:0] f);
		int unsigned          k, r, p, y, c;
		logic [SLOT_BITS-1:0] code;
		k = pack_col;
		r = row_in_strip;
		p = pack_slot;
		code = (p < 6) ? cfg_order[SLOT_BITS*p +: SLOT_BITS] : SLOT_NONE;
		case (f)
			FMT_GRAY: return (k >> 3) * 64 + (r & 7) * 8 + (k & 7);
			FMT_444:  return (k >> 3) * 192 + (r & 7) * 8 + (k & 7) + 64 * (p % 3);
			FMT_422: begin
				y = (k >> 3) * 256 + ((k & 7) >> 2) * 64 + (r & 7) * 8 + (k & 3) * 2;
				c = (k >> 3) * 256 + 128 + (r & 7) * 8 + (k & 7);
			end
			FMT_420: begin
				y = (k >> 3) * 384 + (r >> 3) * 128 + ((k & 7) >> 2) * 64
					+ (r & 7) * 8 + (k & 3) * 2;
				if (r & 1)
					return y + (p & 1);
				c = (k >> 3) * 384 + 256 + r * 4 + (k & 7);
			end
			default: begin
				y = (k >> 3) * 384 + ((k & 7) >> 1) * 64 + (r & 7) * 8 + (k & 1) * 4;
				c = (k >> 3) * 384 + 256 + (r & 7) * 8 + (k & 7);
				if (code == SLOT_Y2)
					return y + 2;
				if (code == SLOT_Y3)
					return y + 3;
			end
		endcase
		if (code == SLOT_Y0)
			return y;
		if (code == SLOT_Y1)
			return y + 1;
		if (code == SLOT_U)
			return c;
		if (code == SLOT_V)
			return c + 64;
		return NO_ADDR;
	endfunction

	function automatic void clear_pointers();
		fill_count   = 0;
		pack_col     = 0;
		row_in_strip = 0;
		pack_slot    = 0;
		read_ptr     = 0;
	endfunction

	// register write as seen by the buffer: any known index also restarts the strip
	function automatic void apply_register(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] value);
		case (idx)
			REG_FORMAT: cfg_format = value[FMT_BITS-1:0];
			REG_WIDTH:  cfg_width  = value[CFG_WIDTH_BITS-1:0];
			REG_ORDER:  cfg_order  = value[ORDER_BITS-1:0];
			default:    return;
		endcase
		clear_pointers();
	endfunction

	// advance the buffer by one transaction and queue the result it must give
	function automatic void predict_buffer_op(input logic [OP_BITS-1:0] o,
		input logic [DATA_BITS-1:0] s);
		logic [FMT_BITS-1:0] f;
		int unsigned         w, sw, pw, a;
		res_t                r;
		f = eff_format();
		w = eff_width();
		sw = strip_words(f, w);
		r = '0;
		case (o)
			OP_WRITE: begin
				if (w == 0 || fill_count >= sw) begin
					r.status = ST_DROP;
				end else begin
					// unused slot codes are counted but not stored
					a = block_addr(f);
					if (a < STORE_WORDS)
						strip_image[a] = s;
					fill_count++;
					pack_slot++;
					if (pack_slot >= pack_words(f)) begin
						pack_slot = 0;
						pack_col++;
						if (pack_col >= packs_in_line(f, w)) begin
							pack_col = 0;
							row_in_strip = (row_in_strip + 1) & 15;
						end
					end
				end
			end
			OP_READ: begin
				// ready once one line (a row pair for 4:2:0) is in
				pw = padded_words();
				if (w == 0 || pw == 0 || fill_count < (sw >> 3)) begin
					r.status = ST_NOT_READY;
				end else begin
					a = read_ptr % pw;
					r.data = strip_image[a];
					read_ptr = (a + 1 == pw) ? 0 : a + 1;
				end
			end
			OP_CLEAR: clear_pointers();
			default: ;
		endcase
		buffer_results_q.push_back(r);
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		fail_count++;
		$display("mismatch on result %0d: %s got %0d, expected %0d",
			checked_count, what, got, want);
	endtask

	// Result checker: every accepted result against the oldest prediction.
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (buffer_results_q.size() == 0) begin
				report_mismatch("result with nothing pending, status", 32'(status), 0);
			end else begin
				want = buffer_results_q.pop_front();
				if (read_data !== want.data)
					report_mismatch("read_data", 32'(read_data), 32'(want.data));
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
			end
			checked_count++;
		end
	end

	// ------------------------------------------------------------------
	// Sender side. send_op holds valid until the transaction is taken and
	// predicts it at that edge. With idle_on the sender runs in bursts of
	// 1..16 transactions separated by idle gaps.
	// ------------------------------------------------------------------
	task automatic send_op(input logic [OP_BITS-1:0] o, input logic [DATA_BITS-1:0] s);
		int gap;
		@(negedge clk);
		if (idle_on && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		op       <= o;
		sample   <= s;
		do @(posedge clk); while (!in_ready);
		predict_buffer_op(o, s);
		item_count++;
	endtask

	// Must follow the last send_op directly, or a held valid repeats the
	// transaction. Waits until every predicted result has been delivered.
	task automatic drain_input();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (buffer_results_q.size() != 0)
			@(negedge clk);
	endtask

	// register writes only with the buffer idle: every result has come back
	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] value);
		drain_input();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, value);
		setting_count++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Slot order that suits the format: a shuffle of the format's slot codes in
	// the low nibbles, random codes above them. Gray and 4:4:4 ignore the order.
	function automatic logic [ORDER_BITS-1:0] slot_order_for(input logic [FMT_BITS-1:0] f);
		logic [SLOT_BITS-1:0]  codes [6];
		logic [SLOT_BITS-1:0]  t;
		logic [ORDER_BITS-1:0] ord;
		int                    n, j;
		ord = ORDER_BITS'($urandom);
		codes = '{SLOT_Y0, SLOT_Y1, SLOT_U, SLOT_V, SLOT_Y2, SLOT_Y3};
		n = (f == FMT_411) ? 6 : (f == FMT_420 || f == FMT_422) ? 4 : 0;
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = codes[i];
			codes[i] = codes[j];
			codes[j] = t;
		end
		for (int i = 0; i < n; i++)
			ord[SLOT_BITS*i +: SLOT_BITS] = codes[i];
		return ord;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset settings (4:2:2, 640 wide): read before any line, spare op,
	// a couple of writes at the sample extremes, clear
	task automatic test_reset_defaults();
		send_op(OP_READ, 8'h00);
		send_op(OP_SPARE, 8'hFF);
		send_op(OP_WRITE, 8'hFF);
		send_op(OP_WRITE, 8'h00);
		send_op(OP_CLEAR, 8'hA5);
	endtask

	// gray, one pixel wide: a strip is eight samples, the ninth is dropped;
	// a write to the unknown register index must leave the pointers alone
	task automatic test_tiny_gray_strip();
		logic [DATA_BITS-1:0] pattern [8];
		pattern = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
		write_register(REG_FORMAT, CFG_DATA_BITS'(FMT_GRAY));
		write_register(REG_WIDTH, CFG_DATA_BITS'(1));
		foreach (pattern[i])
			send_op(OP_WRITE, pattern[i]);
		send_op(OP_WRITE, 8'h3C);
		write_register(REG_SPARE, '1);
		repeat (3) send_op(OP_READ, 8'hFF);
	endtask

	// zero effective width: writes drop, reads are never ready
	task automatic test_zero_width();
		write_register(REG_WIDTH, CFG_DATA_BITS'(0));
		send_op(OP_WRITE, 8'h12);
		send_op(OP_READ, 8'h00);
	endtask

	// Random strips. Each phase picks a setting, fills the strip with random
	// samples (plus a few past full), sprinkles early reads, clears and spare
	// ops, then reads the store out, sometimes through the wrap point. The
	// first phases pin the format to each value 0..7, the width extremes and
	// the all-zero and all-ones stream orders; later phases are random and
	// some are pure noise. Mid widths fill a line or so, the largest widths
	// only take a few transactions.
	task automatic test_random_strips();
		int                       phase;
		int unsigned              start_items, sw, pw, n_wr, n_rd, pick, wval;
		logic [FMT_BITS-1:0]      fmt;
		logic [CFG_DATA_BITS-1:0] order;
		bit                       wrote;
		phase = 0;
		start_items = item_count;
		while (phase < 10 || item_count - start_items < 1000) begin
			idle_on = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 15;
				2: stall_pct = 50;
				default: stall_pct = 80;
			endcase

			fmt = (phase < 8) ? FMT_BITS'(phase) : FMT_BITS'($urandom_range(0, 7));
			if (phase == 0)
				wval = 4095;
			else if (phase == 3)
				wval = 2048;
			else if ($urandom_range(0, 9) == 0)
				wval = $urandom_range(15, 40);
			else
				wval = $urandom_range(0, 14);
			if (phase == 1)
				order = '0;
			else if (phase == 2)
				order = '1;
			else if ($urandom_range(0, 9) < 2)
				order = CFG_DATA_BITS'($urandom);
			else
				order = slot_order_for(fmt);

			// later phases change only some registers; one write is enough
			// to restart the strip
			wrote = 1'b0;
			if (phase < 8 || $urandom_range(0, 1)) begin
				write_register(REG_FORMAT, CFG_DATA_BITS'(fmt));
				wrote = 1'b1;
			end
			if (phase < 8 || $urandom_range(0, 1)) begin
				write_register(REG_WIDTH, CFG_DATA_BITS'(wval));
				wrote = 1'b1;
			end
			if (phase < 8 || $urandom_range(0, 1)) begin
				write_register(REG_ORDER, order);
				wrote = 1'b1;
			end
			if (!wrote)
				write_register(REG_FORMAT, CFG_DATA_BITS'(fmt));
			if ($urandom_range(0, 7) == 0)
				write_register(REG_SPARE, CFG_DATA_BITS'($urandom));

			sw = strip_words(eff_format(), eff_width());
			pw = padded_words();
			if (phase >= 8 && $urandom_range(0, 4) == 0) begin
				repeat (150)
					send_op(OP_BITS'($urandom_range(0, 3)), DATA_BITS'($urandom));
			end else begin
				if (sw > 2000)
					n_wr = $urandom_range(16, 48);
				else if (sw > 200)
					n_wr = (sw >> 3) + $urandom_range(8, 40);
				else
					n_wr = sw + $urandom_range(0, 6);
				for (int i = 0; i < n_wr; i++) begin
					pick = $urandom_range(0, 299);
					if (pick < 36)
						send_op(OP_READ, DATA_BITS'($urandom));
					else if (pick == 36)
						send_op(OP_CLEAR, DATA_BITS'($urandom));
					else if (pick < 40)
						send_op(OP_SPARE, DATA_BITS'($urandom));
					else
						send_op(OP_WRITE, DATA_BITS'($urandom));
				end
				// small stores always wrap, larger ones now and then
				if (pw <= 64 || (pw <= 512 && $urandom_range(0, 3) == 0))
					n_rd = pw + $urandom_range(1, 16);
				else
					n_rd = $urandom_range(8, 40);
				for (int i = 0; i < n_rd; i++) begin
					if ($urandom_range(0, 19) == 0)
						send_op(OP_WRITE, DATA_BITS'($urandom));
					else
						send_op(OP_READ, DATA_BITS'($urandom));
				end
			end
			phase++;
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_FORMAT;
		cfg_data   = '0;
		in_valid   = 1'b0;
		op         = OP_WRITE;
		sample     = '0;
		out_ready  = 1'b0;
		idle_on    = 1'b1;
		burst_left = 0;
		stall_pct  = 30;
		stall_left = 0;
		cycle_count   = 0;
		fail_count    = 0;
		checked_count = 0;
		item_count    = 0;
		setting_count = 0;

		// model state after reset: store swept to zero, reset register values
		foreach (strip_image[i])
			strip_image[i] = '0;
		cfg_format = FMT_RESET;
		cfg_width  = WIDTH_RESET;
		cfg_order  = ORDER_RESET;
		clear_pointers();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// send_op waits out the clearing sweep through in_ready
		test_reset_defaults();
		test_tiny_gray_strip();
		test_zero_width();
		test_random_strips();

		drain_input();
		repeat (8) @(posedge clk);
		if (buffer_results_q.size() != 0)
			report_mismatch("results never delivered", buffer_results_q.size(), 0);

		$display("%0d transactions sent under %0d register writes, %0d results checked",
			item_count, setting_count, checked_count);
		$display("formats 0..7, widths 0..4095, mismatches: %0d", fail_count);
		if (fail_count == 0)
			$display("[raster_to_mcu_block_buffer_unit] OK");
		else
			$display("[raster_to_mcu_block_buffer_unit] ERROR");
		$finish;
	end

endmodule
